>>> rtl/core/keypad_auto_repeat_top_macros.svh
// Assertion macros for the keypad auto-repeat top level.
`ifndef KEYPAD_AUTO_REPEAT_TOP_MACROS_SVH
`define KEYPAD_AUTO_REPEAT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define KAR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad auto-repeat check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define KAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad auto-repeat check failed");

`endif

>>> rtl/core/kar_pkg.sv
// Shared types and constants for the keypad auto-repeat block.
package kar_pkg;

  localparam int KEY_W     = 16;
  localparam int KEY_POS_W = 4;
  localparam int TICK_W    = 8;
  localparam int DELAY_W   = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ALT_LAYOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEXT_DELAY  = 2'd2;

  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 7'd15;
  localparam logic [DELAY_W-1:0] NEXT_DELAY_RST  = 7'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic sample;
    logic clear;
    logic alt_layout;
  } latch_ctrl_t;

  typedef struct packed {
    logic [KEY_W-1:0] seen_down;
    logic [KEY_W-1:0] down_again;
    logic [KEY_W-1:0] let_go;
  } latch_state_t;

endpackage

>>> rtl/core/kar_item_if.sv
// Input item channel: key sample or poll.
interface kar_item_if import kar_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [KEY_W-1:0]  raw_keys;
  logic [TICK_W-1:0] tick_now;

  modport source (output valid, output op, output raw_keys, output tick_now, input ready);
  modport sink   (input valid, input op, input raw_keys, input tick_now, output ready);
endinterface

>>> rtl/core/kar_result_if.sv
// Result channel: pressed and held key masks.
interface kar_result_if import kar_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] pressed_keys;
  logic [KEY_W-1:0] held_keys;

  modport source (output valid, output pressed_keys, output held_keys, input ready);
  modport sink   (input valid, input pressed_keys, input held_keys, output ready);
endinterface

>>> rtl/core/kar_latches.sv
// Layout remap and sticky key latches fed by sample items.
module kar_latches import kar_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  latch_ctrl_t      ctrl,
  input  logic [KEY_W-1:0] raw_keys,
  input  logic [KEY_W-1:0] held_mask,
  output latch_state_t     latch
);

  logic [KEY_W-1:0] keys;
  logic [KEY_W-1:0] alt_keys;

  // alternate console bit order to standard order; unmapped bits drop
  always_comb begin
    alt_keys     = '0;
    alt_keys[12] = raw_keys[11];
    alt_keys[3]  = raw_keys[10];
    alt_keys[2]  = raw_keys[8];
    alt_keys[6]  = raw_keys[7];
    alt_keys[1]  = raw_keys[6];
    alt_keys[7]  = raw_keys[3];
    alt_keys[4]  = raw_keys[2];
    alt_keys[5]  = raw_keys[0];
  end

  assign keys = ctrl.alt_layout ? alt_keys : raw_keys;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      latch <= '0;
    end else if (ctrl.sample) begin
      latch.seen_down  <= latch.seen_down | keys;
      latch.down_again <= latch.down_again | (keys & latch.let_go);
      latch.let_go     <= latch.let_go | (held_mask & ~keys);
    end
  end

endmodule

>>> rtl/core/keypad_auto_repeat_top.sv
// Top level of the keypad typematic auto-repeat engine.
//
//   channel  dir  handshake          payload
//   item     in   valid/ready        op, raw_keys, tick_now
//   result   out  valid/ready        pressed_keys, held_keys
//   cfg      in   cfg_we only        cfg_index, cfg_data
//
// A sample item (op 0) is latched in the transfer cycle.
// A poll item walks keys 1..NUM_KEYS one per cycle through a single due-time
// subtract/compare and deadline adder, stopping at the first reporting key,
// then passes through flush, which loads the output register.
// item.ready is high only while idle. The result sits in an output register,
// so a new item is taken while the last result waits; a poll that finishes
// while that register is still full holds in flush until it drains.
// rst (synchronous) clears all latches, held mask, deadlines and config.

`include "keypad_auto_repeat_top_macros.svh"

module keypad_auto_repeat_top import kar_pkg::*; #(
  parameter int NUM_KEYS = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  kar_item_if.sink             item,
  kar_result_if.source         result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]   cfg_data
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // configuration registers
  logic               alt_layout;
  logic [DELAY_W-1:0] first_delay;
  logic [DELAY_W-1:0] next_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_layout  <= 1'b0;
      first_delay <= FIRST_DELAY_RST;
      next_delay  <= NEXT_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALT_LAYOUT:  alt_layout  <= cfg_data[0];
        CFG_FIRST_DELAY: first_delay <= cfg_data;
        CFG_NEXT_DELAY:  next_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t             state, state_next;
  logic [IDX_W-1:0]   key_idx;
  logic [TICK_W-1:0]  tick;
  logic [KEY_W-1:0]   held_mask;
  logic [KEY_W-1:0]   pressed;
  logic [TICK_W-1:0]  repeat_due [NUM_KEYS];
  logic               out_valid;
  logic [KEY_W-1:0]   out_pressed;
  logic [KEY_W-1:0]   out_held;

  logic item_xfer;
  logic slot_free;
  assign item_xfer = item.valid && item.ready;
  assign slot_free = !out_valid || result.ready;
  assign item.ready = (state == ST_IDLE);

  // sticky latches
  latch_ctrl_t  lctrl;
  latch_state_t latch;

  assign lctrl.sample     = item_xfer && (item.op == OP_SAMPLE);
  assign lctrl.clear      = (state == ST_FLUSH) && slot_free;
  assign lctrl.alt_layout = alt_layout;

  kar_latches u_latches (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lctrl),
    .raw_keys  (item.raw_keys),
    .held_mask (held_mask),
    .latch     (latch)
  );

  // current key: bit position is index + 1
  logic [KEY_POS_W-1:0] key_pos;
  logic [KEY_W-1:0]     key_bit;
  logic                 sd, da, lg, hm;
  assign key_pos = KEY_POS_W'(key_idx) + KEY_POS_W'(1);
  assign key_bit = KEY_W'(1) << key_pos;
  assign sd = latch.seen_down[key_pos];
  assign da = latch.down_again[key_pos];
  assign lg = latch.let_go[key_pos];
  assign hm = held_mask[key_pos];

  // shared due unit: wrap-around compare and deadline add
  logic [TICK_W-1:0] due_cur;
  logic [TICK_W-1:0] due_diff;
  logic              not_due;
  logic              use_first;
  logic [TICK_W-1:0] due_new;
  assign due_cur  = repeat_due[key_idx];
  assign due_diff = due_cur - tick;
  assign not_due  = !due_diff[TICK_W-1];
  assign due_new  = tick + TICK_W'(use_first ? first_delay : next_delay);

  logic stop, do_press, hm_set, hm_clr, due_we, last_key;
  assign last_key = (key_idx == IDX_W'(NUM_KEYS - 1));

  always_comb begin
    stop       = 1'b0;
    do_press   = 1'b0;
    hm_set     = 1'b0;
    hm_clr     = 1'b0;
    due_we     = 1'b0;
    use_first  = 1'b1;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_xfer && (item.op == OP_POLL)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sd) begin
          hm_clr = 1'b1;
        end else if (da) begin
          stop     = 1'b1;
          do_press = 1'b1;
          hm_set   = 1'b1;
          due_we   = 1'b1;
        end else if (hm) begin
          hm_clr = lg;
          if (!not_due) begin
            stop      = 1'b1;
            use_first = 1'b0;
            do_press  = !lg;
            due_we    = !lg;
          end
        end else begin
          stop     = 1'b1;
          do_press = !lg;
          hm_set   = !lg;
          due_we   = !lg;
        end
        if (stop || last_key) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask <= '0;
      for (int i = 0; i < NUM_KEYS; i++) repeat_due[i] <= '0;
    end else begin
      if (hm_set)      held_mask <= held_mask | key_bit;
      else if (hm_clr) held_mask <= held_mask & ~key_bit;
      if (due_we) repeat_due[key_idx] <= due_new;
    end
  end

  // per-poll work registers
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      tick    <= item.tick_now;
      key_idx <= '0;
      pressed <= '0;
    end else if (state == ST_SCAN) begin
      if (do_press) pressed <= key_bit;
      if (!stop && !last_key) key_idx <= key_idx + IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lctrl.clear) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lctrl.clear) begin
      out_pressed <= pressed;
      out_held    <= held_mask;
    end
  end

  assign result.valid        = out_valid;
  assign result.pressed_keys = out_pressed;
  assign result.held_keys    = out_held;

  // checks
  `KAR_ASSERT_IMPL(a_scan_idx_range, state == ST_SCAN, key_idx <= IDX_W'(NUM_KEYS - 1))
  `KAR_ASSERT_IMPL(a_one_press, state == ST_FLUSH, $onehot0(pressed) && !pressed[0])
  `KAR_ASSERT_NEXT(a_latch_cleared, lctrl.clear, latch == '0 && out_valid)
  `KAR_ASSERT_NEXT(a_stop_flush, state == ST_SCAN && stop, state == ST_FLUSH)

endmodule
